// ===== hw/rtl/y86_pkg.sv =====
`default_nettype none
package y86_pkg;

  localparam int DEF_MEM_BYTES = 8192;

  localparam logic [1:0] ST_AOK = 2'd0;
  localparam logic [1:0] ST_HLT = 2'd1;
  localparam logic [1:0] ST_ADR = 2'd2;
  localparam logic [1:0] ST_INS = 2'd3;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_EXEC  = 2'd1;
  localparam logic [1:0] ACT_RDREG = 2'd2;
  localparam logic [1:0] ACT_RDMEM = 2'd3;

  localparam logic [3:0] I_HALT  = 4'h0;
  localparam logic [3:0] I_NOP   = 4'h1;
  localparam logic [3:0] I_CMOV  = 4'h2;
  localparam logic [3:0] I_IRMOV = 4'h3;
  localparam logic [3:0] I_RMMOV = 4'h4;
  localparam logic [3:0] I_MRMOV = 4'h5;
  localparam logic [3:0] I_ALU   = 4'h6;
  localparam logic [3:0] I_JXX   = 4'h7;
  localparam logic [3:0] I_CALL  = 4'h8;
  localparam logic [3:0] I_RET   = 4'h9;
  localparam logic [3:0] I_PUSH  = 4'hA;
  localparam logic [3:0] I_POP   = 4'hB;

  localparam logic [3:0] ALU_ADD = 4'h0;
  localparam logic [3:0] ALU_SUB = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;

  localparam logic [3:0] C_ALWAYS = 4'h0;
  localparam logic [3:0] C_LE     = 4'h1;
  localparam logic [3:0] C_LT     = 4'h2;
  localparam logic [3:0] C_EQ     = 4'h3;
  localparam logic [3:0] C_NE     = 4'h4;
  localparam logic [3:0] C_GE     = 4'h5;
  localparam logic [3:0] C_GT     = 4'h6;

  localparam logic [3:0] RSP_ID = 4'h4;
  localparam logic [3:0] R_NONE = 4'hF;
  localparam logic [3:0] WORD_BYTES = 4'd8;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_CLEAR, OP_LOAD, OP_RDREG, OP_MEMRD, OP_MEMCAP,
    OP_FETCH0, OP_CAP0, OP_FETCH1, OP_CAP1, OP_WORD_NP, OP_IMM_DONE,
    OP_RDA, OP_RDB, OP_EXE, OP_WORD_ADDR, OP_WR_BYTE, OP_WR_RSP,
    OP_WR_DST, OP_SET_PC, OP_SET_ST
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] st;
    logic [3:0] cnt;
  } dp_cmd_t;

  typedef struct packed {
    logic       run_ok;
    logic [3:0] icode;
    logic       pc_bad;
    logic       np_bad;
    logic       imm_bad;
    logic       addr_bad;
    logic       ra_none;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/y86_dp.sv =====
`default_nettype none
module y86_dp #(
  parameter int MEM_BYTES = y86_pkg::DEF_MEM_BYTES
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire y86_pkg::dp_cmd_t             cmd,
  input  wire logic [$clog2(MEM_BYTES)-1:0] clr_addr,
  input  wire logic [12:0]                  mem_address,
  input  wire logic [7:0]                   byte_value,
  input  wire logic [3:0]                   reg_index,
  output y86_pkg::dp_stat_t                 stat,
  output logic [1:0]                        status,
  output logic signed [63:0]                pc_value,
  output logic [2:0]                        flags,
  output logic signed [63:0]                read_data
);
  import y86_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [63:0] MEM_LIM  = 64'(MEM_BYTES);
  localparam logic [63:0] WORD_LIM = 64'(MEM_BYTES - 8);

  logic [7:0]  mem [MEM_BYTES];
  logic [63:0] rf [15];
  logic [63:0] pc, np, imm, val_a, val_b, addr, aluv, word, sdata, rdata;
  logic [3:0]  icode, ifun, ra, rb;
  logic        cnd;
  logic [2:0]  cc;
  logic [1:0]  run_st;
  logic [12:0] in_addr;
  logic [7:0]  in_byte;
  logic [3:0]  in_reg;
  logic [7:0]  mrd;

  logic [63:0]   in_addr64;
  logic          in_ok;
  logic [AW-1:0] m_addr;
  logic          m_we;
  logic [7:0]    m_wd;
  logic [3:0]    rd_id;
  logic [63:0]   rv;
  logic [63:0]   alu_r;
  logic          alu_ov;
  logic          cond;
  logic          lt;
  logic          wr_en;
  logic [3:0]    wr_id;
  logic [63:0]   wr_data;
  logic          stack_op;

  assign in_addr64 = {51'd0, in_addr};
  assign in_ok = in_addr64 < MEM_LIM;
  assign stack_op = (icode == I_CALL) || (icode == I_RET) || (icode == I_PUSH)
                    || (icode == I_POP);

  always_comb begin
    m_addr = '0;
    m_we = 1'b0;
    m_wd = 8'd0;
    case (cmd.op)
      OP_CLEAR: begin
        m_addr = clr_addr;
        m_we = 1'b1;
      end
      OP_LOAD: begin
        m_addr = in_addr64[AW-1:0];
        m_we = in_ok;
        m_wd = in_byte;
      end
      OP_MEMRD:     m_addr = in_addr64[AW-1:0];
      OP_FETCH0:    m_addr = pc[AW-1:0];
      OP_FETCH1:    m_addr = np[AW-1:0];
      OP_WORD_NP:   m_addr = np[AW-1:0] + AW'(cmd.cnt);
      OP_WORD_ADDR: m_addr = addr[AW-1:0] + AW'(cmd.cnt);
      OP_WR_BYTE: begin
        m_addr = addr[AW-1:0] + AW'(cmd.cnt);
        m_we = 1'b1;
        m_wd = sdata[7:0];
      end
      default: m_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (m_we) begin
      mem[m_addr] <= m_wd;
    end
    mrd <= mem[m_addr];
  end

  always_comb begin
    case (cmd.op)
      OP_RDA:   rd_id = ra;
      OP_RDB:   rd_id = stack_op ? RSP_ID : rb;
      OP_RDREG: rd_id = in_reg;
      default:  rd_id = R_NONE;
    endcase
    rv = (rd_id == R_NONE) ? 64'd0 : rf[rd_id];
  end

  always_comb begin
    case (ifun)
      ALU_ADD: alu_r = val_b + val_a;
      ALU_SUB: alu_r = val_b - val_a;
      ALU_AND: alu_r = val_b & val_a;
      ALU_XOR: alu_r = val_b ^ val_a;
      default: alu_r = 64'd0;
    endcase
    alu_ov = 1'b0;
    if (ifun == ALU_ADD) begin
      alu_ov = (val_a[63] == val_b[63]) && (alu_r[63] != val_a[63]);
    end else if (ifun == ALU_SUB) begin
      alu_ov = (val_a[63] != val_b[63]) && (alu_r[63] != val_b[63]);
    end
  end

  assign lt = cc[1] != cc[0];
  always_comb begin
    case (ifun)
      C_ALWAYS: cond = 1'b1;
      C_LE:     cond = lt || cc[2];
      C_LT:     cond = lt;
      C_EQ:     cond = cc[2];
      C_NE:     cond = !cc[2];
      C_GE:     cond = !lt;
      C_GT:     cond = !lt && !cc[2];
      default:  cond = 1'b0;
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    wr_id = R_NONE;
    wr_data = 64'd0;
    if (cmd.op == OP_WR_RSP) begin
      wr_en = 1'b1;
      wr_id = RSP_ID;
      wr_data = ((icode == I_CALL) || (icode == I_PUSH)) ? addr : addr + 64'd8;
    end else if (cmd.op == OP_WR_DST) begin
      case (icode)
        I_CMOV: begin
          wr_en = cnd;
          wr_id = rb;
          wr_data = val_a;
        end
        I_IRMOV: begin
          wr_en = 1'b1;
          wr_id = rb;
          wr_data = imm;
        end
        I_ALU: begin
          wr_en = 1'b1;
          wr_id = rb;
          wr_data = aluv;
        end
        I_MRMOV, I_POP: begin
          wr_en = 1'b1;
          wr_id = ra;
          wr_data = word;
        end
        default: wr_en = 1'b0;
      endcase
    end
    if (wr_id == R_NONE) begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 15; i++) begin
        rf[i] <= 64'd0;
      end
      pc <= 64'd0;
      cc <= 3'd4;
      run_st <= ST_AOK;
      rdata <= 64'd0;
    end else begin
      case (cmd.op)
        OP_ACCEPT: begin
          in_addr <= mem_address;
          in_byte <= byte_value;
          in_reg <= reg_index;
          rdata <= 64'd0;
        end
        OP_RDREG:  rdata <= rv;
        OP_MEMCAP: rdata <= in_ok ? {56'd0, mrd} : 64'd0;
        OP_FETCH0: begin
          np <= pc + 64'd1;
          ra <= R_NONE;
          rb <= R_NONE;
          imm <= 64'd0;
        end
        OP_CAP0: begin
          icode <= mrd[7:4];
          ifun <= mrd[3:0];
        end
        OP_CAP1: begin
          ra <= mrd[7:4];
          rb <= mrd[3:0];
          np <= np + 64'd1;
        end
        OP_WORD_NP, OP_WORD_ADDR: begin
          if (cmd.cnt != 4'd0) begin
            word <= {mrd, word[63:8]};
          end
        end
        OP_IMM_DONE: begin
          imm <= word;
          np <= np + 64'd8;
        end
        OP_RDA: val_a <= rv;
        OP_RDB: val_b <= rv;
        OP_EXE: begin
          case (icode)
            I_RMMOV, I_MRMOV: addr <= imm + val_b;
            I_CALL, I_PUSH:   addr <= val_b - 64'd8;
            default:          addr <= val_b;
          endcase
          aluv <= alu_r;
          cnd <= cond;
          sdata <= (icode == I_CALL) ? np : val_a;
          if (icode == I_ALU) begin
            cc <= {alu_r == 64'd0, alu_r[63], alu_ov};
          end
        end
        OP_WR_BYTE: sdata <= {8'd0, sdata[63:8]};
        OP_SET_PC: begin
          case (icode)
            I_JXX:   pc <= cnd ? imm : np;
            I_CALL:  pc <= imm;
            I_RET:   pc <= word;
            default: pc <= np;
          endcase
        end
        OP_SET_ST: run_st <= cmd.st;
        default: run_st <= run_st;
      endcase
      if (wr_en) begin
        rf[wr_id] <= wr_data;
      end
    end
  end

  assign stat.run_ok   = run_st == ST_AOK;
  assign stat.icode    = icode;
  assign stat.pc_bad   = pc >= MEM_LIM;
  assign stat.np_bad   = np >= MEM_LIM;
  assign stat.imm_bad  = np > WORD_LIM;
  assign stat.addr_bad = addr > WORD_LIM;
  assign stat.ra_none  = ra == R_NONE;

  assign status = run_st;
  assign pc_value = pc;
  assign flags = cc;
  assign read_data = rdata;

endmodule
`default_nettype wire

// ===== hw/rtl/y86_ctrl.sv =====
`default_nettype none
module y86_ctrl #(
  parameter int MEM_BYTES = y86_pkg::DEF_MEM_BYTES
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   action,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  input  wire y86_pkg::dp_stat_t            stat,
  output y86_pkg::dp_cmd_t                  cmd,
  output logic [$clog2(MEM_BYTES)-1:0]      clr_addr
);
  import y86_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);

  typedef enum logic [24:0] {
    S_CLEAR   = 25'd1 << 0,
    S_IDLE    = 25'd1 << 1,
    S_LOAD    = 25'd1 << 2,
    S_RDREG   = 25'd1 << 3,
    S_MEMRD   = 25'd1 << 4,
    S_MEMCAP  = 25'd1 << 5,
    S_F0      = 25'd1 << 6,
    S_F0CAP   = 25'd1 << 7,
    S_DEC     = 25'd1 << 8,
    S_F1      = 25'd1 << 9,
    S_F1CAP   = 25'd1 << 10,
    S_IMMCHK  = 25'd1 << 11,
    S_IMM     = 25'd1 << 12,
    S_IMMDONE = 25'd1 << 13,
    S_RDA     = 25'd1 << 14,
    S_RDB     = 25'd1 << 15,
    S_EXE     = 25'd1 << 16,
    S_CHK     = 25'd1 << 17,
    S_DRD     = 25'd1 << 18,
    S_WRSP    = 25'd1 << 19,
    S_WCHK    = 25'd1 << 20,
    S_DWR     = 25'd1 << 21,
    S_DST     = 25'd1 << 22,
    S_PC      = 25'd1 << 23,
    S_RESP    = 25'd1 << 24
  } state_t;

  state_t        state, state_next;
  logic [3:0]    cnt, cnt_next;
  logic [AW-1:0] clr, clr_next;
  logic          need_regs, need_imm;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= 4'd0;
      clr <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      clr <= clr_next;
    end
  end

  assign need_regs = ((stat.icode >= I_CMOV) && (stat.icode <= I_ALU))
                     || (stat.icode == I_PUSH) || (stat.icode == I_POP);
  assign need_imm = ((stat.icode >= I_IRMOV) && (stat.icode <= I_MRMOV))
                    || (stat.icode == I_JXX) || (stat.icode == I_CALL);

  always_comb begin
    state_next = state;
    cnt_next = 4'd0;
    clr_next = clr;
    cmd.op = OP_NONE;
    cmd.st = ST_AOK;
    cmd.cnt = cnt;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        clr_next = clr + AW'(1);
        if (clr == AW'(MEM_BYTES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          case (action)
            ACT_LOAD:  state_next = S_LOAD;
            ACT_EXEC:  state_next = S_F0;
            ACT_RDREG: state_next = S_RDREG;
            default:   state_next = S_MEMRD;
          endcase
        end
      end
      S_LOAD: begin
        cmd.op = OP_LOAD;
        state_next = S_RESP;
      end
      S_RDREG: begin
        cmd.op = OP_RDREG;
        state_next = S_RESP;
      end
      S_MEMRD: begin
        cmd.op = OP_MEMRD;
        state_next = S_MEMCAP;
      end
      S_MEMCAP: begin
        cmd.op = OP_MEMCAP;
        state_next = S_RESP;
      end
      S_F0: begin
        state_next = S_RESP;
        if (stat.run_ok) begin
          if (stat.pc_bad) begin
            cmd.op = OP_SET_ST;
            cmd.st = ST_ADR;
          end else begin
            cmd.op = OP_FETCH0;
            state_next = S_F0CAP;
          end
        end
      end
      S_F0CAP: begin
        cmd.op = OP_CAP0;
        state_next = S_DEC;
      end
      S_DEC: begin
        if (stat.icode > I_POP) begin
          cmd.op = OP_SET_ST;
          cmd.st = ST_INS;
          state_next = S_RESP;
        end else if (need_regs) begin
          state_next = S_F1;
        end else if (need_imm) begin
          state_next = S_IMMCHK;
        end else begin
          state_next = S_RDA;
        end
      end
      S_F1: begin
        if (stat.np_bad) begin
          cmd.op = OP_SET_ST;
          cmd.st = ST_ADR;
          state_next = S_RESP;
        end else begin
          cmd.op = OP_FETCH1;
          state_next = S_F1CAP;
        end
      end
      S_F1CAP: begin
        cmd.op = OP_CAP1;
        state_next = need_imm ? S_IMMCHK : S_RDA;
      end
      S_IMMCHK: begin
        if (stat.imm_bad) begin
          cmd.op = OP_SET_ST;
          cmd.st = ST_ADR;
          state_next = S_RESP;
        end else begin
          state_next = S_IMM;
        end
      end
      S_IMM: begin
        cmd.op = OP_WORD_NP;
        cnt_next = cnt + 4'd1;
        if (cnt == WORD_BYTES) begin
          cnt_next = 4'd0;
          state_next = S_IMMDONE;
        end
      end
      S_IMMDONE: begin
        cmd.op = OP_IMM_DONE;
        state_next = S_RDA;
      end
      S_RDA: begin
        cmd.op = OP_RDA;
        state_next = S_RDB;
      end
      S_RDB: begin
        cmd.op = OP_RDB;
        state_next = S_EXE;
      end
      S_EXE: begin
        cmd.op = OP_EXE;
        state_next = S_CHK;
      end
      S_CHK: begin
        case (stat.icode)
          I_HALT: begin
            cmd.op = OP_SET_ST;
            cmd.st = ST_HLT;
            state_next = S_RESP;
          end
          I_NOP, I_CMOV, I_IRMOV, I_ALU: state_next = S_DST;
          I_JXX: state_next = S_PC;
          I_RMMOV, I_MRMOV, I_RET: begin
            if (stat.addr_bad) begin
              cmd.op = OP_SET_ST;
              cmd.st = ST_ADR;
              state_next = S_RESP;
            end else begin
              state_next = (stat.icode == I_RMMOV) ? S_DWR : S_DRD;
            end
          end
          I_CALL, I_PUSH: state_next = S_WRSP;
          I_POP: begin
            if (stat.addr_bad || stat.ra_none) begin
              cmd.op = OP_SET_ST;
              cmd.st = ST_INS;
              state_next = S_RESP;
            end else begin
              state_next = S_DRD;
            end
          end
          default: state_next = S_RESP;
        endcase
      end
      S_DRD: begin
        cmd.op = OP_WORD_ADDR;
        cnt_next = cnt + 4'd1;
        if (cnt == WORD_BYTES) begin
          cnt_next = 4'd0;
          state_next = (stat.icode == I_MRMOV) ? S_DST : S_WRSP;
        end
      end
      S_WRSP: begin
        cmd.op = OP_WR_RSP;
        case (stat.icode)
          I_CALL, I_PUSH: state_next = S_WCHK;
          I_POP:          state_next = S_DST;
          default:        state_next = S_PC;
        endcase
      end
      S_WCHK: begin
        if (stat.addr_bad) begin
          cmd.op = OP_SET_ST;
          cmd.st = ST_ADR;
          state_next = S_RESP;
        end else begin
          state_next = S_DWR;
        end
      end
      S_DWR: begin
        cmd.op = OP_WR_BYTE;
        cnt_next = cnt + 4'd1;
        if (cnt == WORD_BYTES - 4'd1) begin
          cnt_next = 4'd0;
          state_next = S_PC;
        end
      end
      S_DST: begin
        cmd.op = OP_WR_DST;
        state_next = S_PC;
      end
      S_PC: begin
        cmd.op = OP_SET_PC;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready = state == S_IDLE;
  assign out_valid = state == S_RESP;
  assign clr_addr = clr;

endmodule
`default_nettype wire

// ===== hw/rtl/y86_64_sequential_core.sv =====
// Y86-64 sequential core: byte memory, fifteen 64-bit registers, pc, flags, status.
// Input channel (in_valid/in_ready): action, mem_address, byte_value, reg_index.
//   action 0 loads a memory byte, 1 executes one instruction, 2 reads a register,
//   3 reads a memory byte.
// Output channel (out_valid/out_ready): status, pc_value, flags, read_data,
//   one result per input transfer.
// One item is in flight at a time; in_ready is high only while the core is idle,
//   which is the cycle after the result transfer.
// Instruction items take longest for mrmov (immediate fetch plus data word read);
//   when status is not ok or pc is out of memory they skip the fetch.
// The single byte-wide memory port sets the instruction time: each immediate and
//   each data word is read or written through it one byte at a time.
// A stalled result holds on the outputs until out_ready; no new input is taken.
// After reset the core clears the byte memory, one byte per cycle, before in_ready
//   rises; registers, pc become zero, flags Z, status ok.
// Once status leaves ok, instruction items change nothing; other items still run.
`default_nettype none
module y86_64_sequential_core #(
  parameter int MEM_BYTES = y86_pkg::DEF_MEM_BYTES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         action,
  input  wire logic [12:0]        mem_address,
  input  wire logic [7:0]         byte_value,
  input  wire logic [3:0]         reg_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic signed [63:0]      pc_value,
  output logic [2:0]              flags,
  output logic signed [63:0]      read_data
);
  import y86_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [AW-1:0] clr_addr;

  y86_ctrl #(.MEM_BYTES(MEM_BYTES)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd),
    .clr_addr  (clr_addr)
  );

  y86_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .clr_addr    (clr_addr),
    .mem_address (mem_address),
    .byte_value  (byte_value),
    .reg_index   (reg_index),
    .stat        (stat),
    .status      (status),
    .pc_value    (pc_value),
    .flags       (flags),
    .read_data   (read_data)
  );

`ifndef NO_ASSERTIONS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_sticky: assert property (@(posedge clk) disable iff (rst)
    (status != ST_AOK) |=> (status == $past(status)))
    else $error("status left a fault or halt state");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(pc_value) && $stable(read_data)
      && $stable(flags)))
    else $error("result changed while stalled");
`endif

endmodule
`default_nettype wire
